### hdl/assert_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hdl/jdc_pkg.sv
package jdc_pkg;

    // register stages from input to the last pipeline stage
    localparam int PIPE_DEPTH = 7;

    // date to day number
    localparam logic [12:0] YEAR_OFFSET   = 13'd4800;
    localparam logic [13:0] RECIP_DIV25   = 14'd5243;     // 2^17 / 25, rounded up
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [22:0] JDN_BIAS_FWD  = 23'd32045;

    // day number to date
    localparam logic [23:0] JDN_BIAS_REV  = 24'd32044;
    localparam logic [26:0] RECIP_CYCLE   = 27'd120414424; // 2^44 / 146097, rounded up
    localparam logic [17:0] DAYS_CYCLE    = 18'd146097;
    localparam logic [18:0] RECIP_QUAD    = 19'd367469;    // 2^29 / 1461, rounded up
    localparam logic [10:0] DAYS_QUAD     = 11'd1461;
    localparam logic [11:0] RECIP_MONTH   = 12'd3427;      // 2^19 / 153, rounded up
    localparam logic [6:0]  YEARS_CENTURY = 7'd100;
    localparam logic [15:0] YEAR_BIAS_REV = 16'd4800;

    typedef struct packed {
        logic [22:0] jdn;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
    } result_t;

    // days before month m of a march-based year, (153*m + 2) / 5
    function automatic logic [8:0] month_days(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd398;
            4'd14:   r = 9'd428;
            4'd15:   r = 9'd459;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/julian_day_converter.sv
// throughput: one conversion per cycle while the skid register is empty, set by the seven-stage pipeline in which
//   every division is a reciprocal multiply followed by a register
// reset: rst_n clears the stage valid bits and the output and skid valid flags;
//   data registers are not reset
module julian_day_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [13:0] year_in,
    input  logic [22:0] jdn_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [22:0] jdn_out,
    output logic [4:0]  day_out,
    output logic [3:0]  month_out,
    output logic [15:0] year_out
);
    import jdc_pkg::*;

    `include "assert_macros.svh"

    // whole pipeline moves together; it freezes only while the skid
    // register holds a beat, so the stall toward the source is a flop
    logic                  advance;
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] mode_reg;

    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // mode travels beside the data to pick the result at the end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode_reg <= {mode_reg[PIPE_DEPTH-2:0], mode};
        end
    end

    // both directions are computed for every beat, same depth each
    logic [22:0] fwd_jdn;
    logic [4:0]  rev_day;
    logic [3:0]  rev_month;
    logic [15:0] rev_year;

    jdc_date_to_jdn u_fwd (
        .clk      (clk),
        .en       (advance),
        .day_in   (day_in),
        .month_in (month_in),
        .year_in  (year_in),
        .jdn      (fwd_jdn)
    );

    jdc_jdn_to_date u_rev (
        .clk    (clk),
        .en     (advance),
        .jdn_in (jdn_in),
        .day    (rev_day),
        .month  (rev_month),
        .year   (rev_year)
    );

    // fields the selected direction does not produce go out as zero
    logic    last_mode;
    result_t pipe_res;
    result_t out_res;

    assign last_mode      = mode_reg[PIPE_DEPTH-1];
    assign pipe_res.jdn   = last_mode ? 23'd0 : fwd_jdn;
    assign pipe_res.day   = last_mode ? rev_day : 5'd0;
    assign pipe_res.month = last_mode ? rev_month : 4'd0;
    assign pipe_res.year  = last_mode ? rev_year : 16'd0;

    jdc_out_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .pipe_valid (v_reg[PIPE_DEPTH-1]),
        .pipe_res   (pipe_res),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (out_res)
    );

    assign jdn_out   = out_res.jdn;
    assign day_out   = out_res.day;
    assign month_out = out_res.month;
    assign year_out  = out_res.year;

    // a frozen pipeline keeps its valid bits
    `ASSERT_NEXT(a_frozen_valid, !advance, $stable(v_reg))
    // a date beat carries no day number
    `ASSERT_IMP(a_date_no_jdn, out_valid && (month_out != 4'd0), jdn_out == 23'd0)
    // a day-number beat carries no date, and a decoded date is in range
    `ASSERT_IMP(a_jdn_no_date, out_valid && (month_out == 4'd0),
                (day_out == 5'd0) && (year_out == 16'd0))
    `ASSERT_IMP(a_date_range, out_valid && (month_out != 4'd0),
                (month_out <= 4'd12) && (day_out != 5'd0))

endmodule

### hdl/jdc_date_to_jdn.sv
module jdc_date_to_jdn (
    input  logic        clk,
    input  logic        en,
    input  logic [4:0]  day_in,
    input  logic [3:0]  month_in,
    input  logic [13:0] year_in,
    output logic [22:0] jdn
);
    import jdc_pkg::*;

    // stage 1: march-based year and month
    logic        shift;
    logic [14:0] y_next, y_reg;
    logic [3:0]  m_next, m_reg;
    logic [4:0]  day_reg;

    assign shift  = (month_in <= 4'd2);
    assign y_next = {1'b0, year_in} + {2'b0, YEAR_OFFSET} - {14'b0, shift};
    assign m_next = shift ? month_in + 4'd9 : month_in - 4'd3;

    // stage 2: year days, quarter year, divide by 25 product, day plus month days
    logic [12:0] q4_next, q4_reg;
    logic [26:0] p100_full;
    logic [25:0] p100_reg;
    logic [23:0] y365_full;
    logic [22:0] y365_reg;
    logic [9:0]  dm_next, dm_reg;

    assign q4_next   = y_reg[14:2];
    assign p100_full = q4_next * RECIP_DIV25;
    assign y365_full = y_reg * DAYS_PER_YEAR;
    assign dm_next   = {5'b0, day_reg} + {1'b0, month_days(m_reg)};

    // stage 3: leap day corrections and bias
    logic [8:0]  q100;
    logic [6:0]  q400;
    logic [22:0] n_next;
    logic [22:0] n_reg [3:PIPE_DEPTH];

    assign q100   = p100_reg[25:17];
    assign q400   = q100[8:2];
    assign n_next = y365_reg + {13'b0, dm_reg} + {10'b0, q4_reg} - {14'b0, q100}
                    + {16'b0, q400} - JDN_BIAS_FWD;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg    <= y_next;
            m_reg    <= m_next;
            day_reg  <= day_in;
            q4_reg   <= q4_next;
            p100_reg <= p100_full[25:0];
            y365_reg <= y365_full[22:0];
            dm_reg   <= dm_next;
            n_reg[3] <= n_next;
            for (int i = 4; i <= PIPE_DEPTH; i++)
            begin
                n_reg[i] <= n_reg[i-1];
            end
        end
    end

    assign jdn = n_reg[PIPE_DEPTH];

endmodule

### hdl/jdc_jdn_to_date.sv
module jdc_jdn_to_date (
    input  logic        clk,
    input  logic        en,
    input  logic [22:0] jdn_in,
    output logic [4:0]  day,
    output logic [3:0]  month,
    output logic [15:0] year
);
    import jdc_pkg::*;

    // stage 1: biased day number
    logic [23:0] a_next, a1_reg, a2_reg, a3_reg;
    logic [25:0] x1_next, x1_reg;

    assign a_next  = {1'b0, jdn_in} + JDN_BIAS_REV;
    assign x1_next = {a_next, 2'b11};

    // stage 2: century quotient by reciprocal
    logic [52:0] p1_next, p1_reg;

    assign p1_next = x1_reg * RECIP_CYCLE;

    // stage 3: days consumed by whole centuries
    logic [7:0]  b_next, b_reg;
    logic [25:0] pb_next, pb_reg;

    assign b_next  = p1_reg[51:44];
    assign pb_next = b_next * DAYS_CYCLE;

    // stage 4: day within century, year quotient product
    logic [23:0] c_diff;
    logic [15:0] c_next, c4_reg, c5_reg;
    logic [17:0] x2;
    logic [36:0] p2_next, p2_reg;
    logic [14:0] yb_next, yb4_reg, yb5_reg, yb6_reg;

    assign c_diff  = a3_reg - pb_reg[25:2];
    assign c_next  = c_diff[15:0];
    assign x2      = {c_next, 2'b11};
    assign p2_next = x2 * RECIP_QUAD;
    assign yb_next = b_reg * YEARS_CENTURY;

    // stage 5: year within century and its days
    logic [6:0]  d_next, d5_reg, d6_reg;
    logic [17:0] pd_next, pd_reg;

    assign d_next  = p2_reg[35:29];
    assign pd_next = d_next * DAYS_QUAD;

    // stage 6: day of year, month quotient product
    logic [15:0] e_diff;
    logic [8:0]  e_next, e_reg;
    logic [10:0] x3;
    logic [22:0] p3_next, p3_reg;

    assign e_diff  = c5_reg - pd_reg[17:2];
    assign e_next  = e_diff[8:0];
    assign x3      = {e_next, 2'b00} + {2'b00, e_next} + 11'd2;
    assign p3_next = x3 * RECIP_MONTH;

    // stage 7: calendar fields
    logic [3:0]  m;
    logic        wrap;
    logic [8:0]  day_full;
    logic [4:0]  day_next, day_reg;
    logic [3:0]  month_next, month_reg;
    logic [15:0] year_next, year_reg;

    assign m          = p3_reg[22:19];
    assign wrap       = (m >= 4'd10);
    assign day_full   = e_reg - month_days(m) + 9'd1;
    assign day_next   = day_full[4:0];
    assign month_next = wrap ? m - 4'd9 : m + 4'd3;
    assign year_next  = {1'b0, yb6_reg} + {9'b0, d6_reg} - YEAR_BIAS_REV + {15'b0, wrap};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= a_next;
            x1_reg    <= x1_next;
            a2_reg    <= a1_reg;
            p1_reg    <= p1_next;
            a3_reg    <= a2_reg;
            b_reg     <= b_next;
            pb_reg    <= pb_next;
            c4_reg    <= c_next;
            yb4_reg   <= yb_next;
            p2_reg    <= p2_next;
            c5_reg    <= c4_reg;
            yb5_reg   <= yb4_reg;
            d5_reg    <= d_next;
            pd_reg    <= pd_next;
            e_reg     <= e_next;
            yb6_reg   <= yb5_reg;
            d6_reg    <= d5_reg;
            p3_reg    <= p3_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
        end
    end

    assign day   = day_reg;
    assign month = month_reg;
    assign year  = year_reg;

endmodule

### hdl/jdc_out_skid.sv
module jdc_out_skid (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pipe_valid,
    input  jdc_pkg::result_t pipe_res,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_stall,
    output jdc_pkg::result_t out_res
);
    import jdc_pkg::*;

    `include "assert_macros.svh"

    logic    out_valid_reg;
    logic    full_reg;
    logic    take;
    result_t out_res_reg;
    result_t skid_res_reg;

    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            full_reg      <= 1'b0;
        end
        else if (full_reg)
        begin
            if (take)
            begin
                full_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_valid_reg <= pipe_valid;
        end
        else if (pipe_valid)
        begin
            full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (full_reg)
        begin
            if (take)
            begin
                out_res_reg <= skid_res_reg;
            end
        end
        else if (!out_valid_reg || take)
        begin
            out_res_reg <= pipe_res;
        end
        else
        begin
            skid_res_reg <= pipe_res;
        end
    end

    assign advance   = !full_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // skid only fills behind a stalled output beat
    `ASSERT_IMP(a_skid_fill_cause, $rose(full_reg), $past(out_valid_reg && out_stall))
    `ASSERT_IMP(a_skid_behind_out, full_reg, out_valid_reg)

endmodule

### dv/tb_julian_day_converter.sv
module tb_julian_day_converter;

    timeunit 1ns;
    timeprecision 1ps;

    import jdc_pkg::*;

    // conversion direction codes
    localparam logic MODE_TO_JDN  = 1'b0;
    localparam logic MODE_TO_DATE = 1'b1;

    // largest day number that maps back into year 9999
    localparam int unsigned JDN_MAX_VALID = 5373484;

    // one conversion request, plus a flag that holds it back until the pipe drains
    typedef struct {
        logic        mode;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [22:0] jdn;
        bit          drain;
    } request_t;

    // dut ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic        mode      = 1'b0;
    logic [4:0]  day_in    = '0;
    logic [3:0]  month_in  = '0;
    logic [13:0] year_in   = '0;
    logic [22:0] jdn_in    = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [22:0] jdn_out;
    logic [4:0]  day_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;

    // requests waiting to be driven, and converted values waiting to come out
    request_t    requests[$];
    result_t     conversions_due[$];

    request_t    req;
    bit          beat_taken  = 1'b0;
    int unsigned total_beats = 0;
    int unsigned accepted    = 0;
    int unsigned mismatches  = 0;
    int unsigned gap_left    = 0;
    int unsigned in_calm     = 0;
    int unsigned stall_left  = 0;
    int unsigned out_calm    = 0;

    julian_day_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .day_in    (day_in),
        .month_in  (month_in),
        .year_in   (year_in),
        .jdn_in    (jdn_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .jdn_out   (jdn_out),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // gregorian date <-> day number, all in 32-bit unsigned wraparound
    function automatic result_t convert_calendar(input logic md, input logic [4:0] d,
                                                 input logic [3:0] mo, input logic [13:0] yr,
                                                 input logic [22:0] jn);
        bit [31:0] shift, y, m, n, a, b, c, q, e, mm;
        result_t   r;
        r = '0;
        if (md == MODE_TO_JDN)
        begin
            // months 0..2 count as part of the previous march-based year
            shift = (mo <= 4'd2) ? 32'd1 : 32'd0;
            y = yr + 32'd4800 - shift;
            m = mo + 32'd12 * shift - 32'd3;
            n = d + (32'd153 * m + 32'd2) / 32'd5 + y * 32'd365 + y / 32'd4
                - y / 32'd100 + y / 32'd400 - 32'd32045;
            r.jdn = n[22:0];
        end
        else
        begin
            a  = jn + 32'd32044;
            b  = (32'd4 * a + 32'd3) / 32'd146097;
            c  = a - (b * 32'd146097) / 32'd4;
            q  = (32'd4 * c + 32'd3) / 32'd1461;
            e  = c - (32'd1461 * q) / 32'd4;
            mm = (32'd5 * e + 32'd2) / 32'd153;
            n  = e - (32'd153 * mm + 32'd2) / 32'd5 + 32'd1;
            r.day = n[4:0];
            n  = mm + 32'd3 - 32'd12 * (mm / 32'd10);
            r.month = n[3:0];
            // early day numbers give a negative year, kept as low 16 bits
            n  = b * 32'd100 + q - 32'd4800 + mm / 32'd10;
            r.year = n[15:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    // date request; the day number field carries junk the dut must ignore
    task automatic add_date(input int unsigned d, input int unsigned mo, input int unsigned yr,
                            input bit drain);
        request_t r;
        r.mode  = MODE_TO_JDN;
        r.day   = d[4:0];
        r.month = mo[3:0];
        r.year  = yr[13:0];
        r.jdn   = 23'($urandom);
        r.drain = drain;
        requests.push_back(r);
        total_beats++;
    endtask

    // day number request; the date fields carry junk the dut must ignore
    task automatic add_jdn(input int unsigned jn, input bit drain);
        request_t r;
        r.mode  = MODE_TO_DATE;
        r.day   = 5'($urandom);
        r.month = 4'($urandom);
        r.year  = 14'($urandom);
        r.jdn   = jn[22:0];
        r.drain = drain;
        requests.push_back(r);
        total_beats++;
    endtask

    // input driver: fields change on the falling edge, a beat holds until taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || beat_taken)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (requests.size() != 0 &&
                         !(requests[0].drain && conversions_due.size() != 0))
                begin
                    req = requests.pop_front();
                    mode     <= req.mode;
                    day_in   <= req.day;
                    month_in <= req.month;
                    year_in  <= req.year;
                    jdn_in   <= req.jdn;
                    in_valid <= 1'b1;
                    // idle gap after this beat: mostly none, sometimes short, rarely long
                    if (in_calm != 0)
                    begin
                        in_calm--;
                        gap_left = 0;
                    end
                    else
                    begin
                        case ($urandom_range(0, 99)) inside
                            [0:59]:  gap_left = 0;
                            [60:89]: gap_left = $urandom_range(1, 3);
                            [90:97]: gap_left = $urandom_range(4, 12);
                            default: gap_left = $urandom_range(20, 60);
                        endcase
                        // now and then a back-to-back stretch
                        if ($urandom_range(0, 49) == 0)
                            in_calm = $urandom_range(20, 80);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output stall pattern, also moved on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_calm != 0)
                begin
                    out_calm--;
                end
                else
                begin
                    case ($urandom_range(0, 99)) inside
                        [0:64]:  stall_left = 0;
                        [65:89]: stall_left = $urandom_range(1, 3);
                        [90:97]: stall_left = $urandom_range(4, 12);
                        default: stall_left = $urandom_range(20, 60);
                    endcase
                    if ($urandom_range(0, 59) == 0)
                        out_calm = $urandom_range(30, 120);
                end
            end
        end
    end

    // monitor: log accepted input beats, check accepted output beats in order
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            beat_taken <= 1'b0;
        end
        else
        begin
            beat_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                conversions_due.push_back(
                    convert_calendar(mode, day_in, month_in, year_in, jdn_in));
                accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (conversions_due.size() == 0)
                begin
                    report_mismatch("result beat with none pending", jdn_out, 0);
                end
                else
                begin
                    want = conversions_due.pop_front();
                    if (jdn_out !== want.jdn)
                        report_mismatch("jdn_out", jdn_out, want.jdn);
                    if (day_out !== want.day)
                        report_mismatch("day_out", day_out, want.day);
                    if (month_out !== want.month)
                        report_mismatch("month_out", month_out, want.month);
                    if (year_out !== want.year)
                        report_mismatch("year_out", year_out, want.year);
                end
            end
        end
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned d, mo, yr;

        // directed: known dates, field extremes, unchecked dates
        add_date(1, 1, 2000, 1'b0);         // 2451545
        add_date(29, 2, 2000, 1'b0);        // leap day, shifted month
        add_date(1, 3, 1900, 1'b0);         // non-leap century
        add_date(15, 10, 1582, 1'b0);       // gregorian start
        add_date(1, 1, 0, 1'b0);            // smallest valid
        add_date(31, 12, 9999, 1'b0);       // largest valid
        add_date(0, 0, 0, 1'b0);            // day and month zero
        add_date(31, 15, 16383, 1'b0);      // all date bits set
        add_date(31, 13, 9999, 1'b0);       // month past december
        add_date(17, 2, 8192, 1'b0);
        add_date(5, 14, 4321, 1'b0);
        // directed: day numbers, including ones before year zero
        add_jdn(0, 1'b1);                   // waits for an empty pipe
        add_jdn(1, 1'b0);
        add_jdn(32044, 1'b0);
        add_jdn(1721119, 1'b0);             // around year zero
        add_jdn(1721058, 1'b0);
        add_jdn(2451545, 1'b0);
        add_jdn(2299161, 1'b0);
        add_jdn(JDN_MAX_VALID, 1'b0);
        add_jdn(JDN_MAX_VALID + 1, 1'b0);
        add_jdn(23'h7FFFFF, 1'b0);          // all bits set
        add_jdn(23'h400000, 1'b0);
        add_jdn(23'h2AAAAA, 1'b0);
        add_jdn(23'h155555, 1'b0);

        // random: mostly in-range values, some using every field bit
        for (int i = 0; i < 550; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    d  = $urandom_range(1, 31);
                    mo = $urandom_range(1, 12);
                    yr = $urandom_range(0, 9999);
                end
                else
                begin
                    d  = $urandom_range(0, 31);
                    mo = $urandom_range(0, 15);
                    yr = $urandom_range(0, 16383);
                end
                add_date(d, mo, yr, i == 0 || $urandom_range(0, 99) == 0);
            end
            else
            begin
                if ($urandom_range(0, 9) < 8)
                    add_jdn($urandom_range(0, JDN_MAX_VALID), $urandom_range(0, 99) == 0);
                else
                    add_jdn($urandom_range(0, 23'h7FFFFF), i == 0);
            end
        end

        // hold reset, then release it on a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // all beats taken, all results back, then a quiet tail before the verdict
        while (accepted != total_beats || conversions_due.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 8) @(negedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
